// ===== hdl/radix_literal_parser_unit_defines.svh =====
// Assertion macros used by the radix literal parser top level.
`ifndef RADIX_LITERAL_PARSER_UNIT_DEFINES_SVH
`define RADIX_LITERAL_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on clk and disabled while in reset.
`define RLP_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("radix literal parser check failed");

// Next-cycle implication, checked on clk and disabled while in reset.
`define RLP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("radix literal parser check failed");

`endif

// ===== hdl/rlp_pkg.sv =====
// Shared constants, codes and types of the radix literal parser.
package rlp_pkg;

  localparam int CELL_BITS     = 16;
  localparam int CHAR_BITS     = 8;
  localparam int BASE_BITS     = 6;
  localparam int OPC_BITS      = 16;
  localparam int SPAN_BITS     = 15;
  localparam int VALUE_BITS    = 16;
  localparam int ACTION_BITS   = 2;
  localparam int CFG_ADDR_BITS = 2;
  localparam int CFG_DATA_BITS = 16;
  // Width used to compare a cell value against the short literal span.
  localparam int CMP_BITS      = (CELL_BITS > SPAN_BITS) ? CELL_BITS : SPAN_BITS;

  // Result actions.
  localparam logic [ACTION_BITS-1:0] ACT_NONE   = 2'd0;
  localparam logic [ACTION_BITS-1:0] ACT_PUSH   = 2'd1;
  localparam logic [ACTION_BITS-1:0] ACT_APPEND = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_BITS-1:0] REG_NUMBER_BASE   = 2'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_LITERAL_OPC   = 2'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_FIRST_SHORT   = 2'd2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_SHORT_SPAN    = 2'd3;

  localparam logic [BASE_BITS-1:0] BASE_RESET = 6'd10;

  // Character codes.
  localparam logic [CHAR_BITS-1:0] CHAR_MINUS   = 8'h2D;
  localparam logic [CHAR_BITS-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [CHAR_BITS-1:0] CHAR_NINE    = 8'h39;
  localparam logic [CHAR_BITS-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_BITS-1:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [CHAR_BITS-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CHAR_BITS-1:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [BASE_BITS-1:0] DIGIT_TEN    = 6'd10;

  typedef struct packed {
    logic [BASE_BITS-1:0] number_base;
    logic [OPC_BITS-1:0]  literal_opcode;
    logic [OPC_BITS-1:0]  first_short_opcode;
    logic [SPAN_BITS-1:0] short_literal_span;
  } cfg_t;

  typedef struct packed {
    logic                   has_res;
    logic                   two_res;
    logic [ACTION_BITS-1:0] action;
    logic [VALUE_BITS-1:0]  first_value;
    logic [VALUE_BITS-1:0]  second_value;
  } conv_res_t;

endpackage

// ===== hdl/rlp_word_conv.sv =====
// Per-word conversion state and the result decode for one character beat.
module rlp_word_conv
  import rlp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  logic [CHAR_BITS-1:0] character,
  input  logic                 word_end,
  input  logic                 compile_mode,
  input  cfg_t                 cfg,
  output conv_res_t            res
);

  logic [CELL_BITS-1:0] acc_r, acc_nxt;
  logic                 neg_r, neg_nxt;
  logic                 bad_r, bad_nxt;
  logic                 start_r, start_nxt;

  logic [CELL_BITS-1:0] acc_upd;
  logic                 neg_upd;
  logic                 bad_upd;
  logic                 is_digit;
  logic                 is_upper;
  logic                 is_lower;
  logic                 letters_ok;
  logic                 digit_ok;
  logic [BASE_BITS-1:0] digit_val;
  logic [CELL_BITS+BASE_BITS-1:0] prod_full;
  logic [CELL_BITS-1:0] acc_sum;
  logic [CELL_BITS-1:0] value;
  logic                 short_fit;

  // Classify the character and form its digit value.
  always_comb begin
    is_digit   = (character >= CHAR_ZERO) && (character <= CHAR_NINE);
    is_upper   = (character >= CHAR_UPPER_A) && (character <= CHAR_UPPER_Z);
    is_lower   = (character >= CHAR_LOWER_A) && (character <= CHAR_LOWER_Z);
    letters_ok = cfg.number_base > DIGIT_TEN;
    digit_ok   = is_digit || (letters_ok && (is_upper || is_lower));
    if (is_digit) begin
      digit_val = BASE_BITS'(character - CHAR_ZERO);
    end else if (is_upper) begin
      digit_val = DIGIT_TEN + BASE_BITS'(character - CHAR_UPPER_A);
    end else begin
      digit_val = DIGIT_TEN + BASE_BITS'(character - CHAR_LOWER_A);
    end
    prod_full = acc_r * cfg.number_base;
    acc_sum   = prod_full[CELL_BITS-1:0] + CELL_BITS'(digit_val);
  end

  // Word state as it stands after this character.
  always_comb begin
    acc_upd = acc_r;
    neg_upd = neg_r;
    bad_upd = bad_r;
    if (start_r && (character == CHAR_MINUS)) begin
      neg_upd = 1'b1;
    end else if (!bad_r) begin
      if (digit_ok) begin
        acc_upd = acc_sum;
      end else begin
        bad_upd = 1'b1;
      end
    end
  end

  // Results of a word that ends with this character.
  always_comb begin
    value     = neg_upd ? (CELL_BITS'(0) - acc_upd) : acc_upd;
    short_fit = !value[CELL_BITS-1] &&
                (CMP_BITS'(value) < CMP_BITS'(cfg.short_literal_span));
    res.has_res      = word_end;
    res.two_res      = 1'b0;
    res.action       = ACT_NONE;
    res.first_value  = '0;
    res.second_value = VALUE_BITS'(value);
    if (bad_upd) begin
      res.action = ACT_NONE;
    end else if (!compile_mode) begin
      res.action      = ACT_PUSH;
      res.first_value = VALUE_BITS'(value);
    end else if (short_fit) begin
      res.action      = ACT_APPEND;
      res.first_value = VALUE_BITS'(CELL_BITS'(value + CELL_BITS'(cfg.first_short_opcode)));
    end else begin
      res.action      = ACT_APPEND;
      res.two_res     = 1'b1;
      res.first_value = VALUE_BITS'(CELL_BITS'(cfg.literal_opcode));
    end
  end

  // A word end clears the state for the next word.
  always_comb begin
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    bad_nxt   = bad_r;
    start_nxt = start_r;
    if (fire) begin
      if (word_end) begin
        acc_nxt   = '0;
        neg_nxt   = 1'b0;
        bad_nxt   = 1'b0;
        start_nxt = 1'b1;
      end else begin
        acc_nxt   = acc_upd;
        neg_nxt   = neg_upd;
        bad_nxt   = bad_upd;
        start_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      neg_r   <= 1'b0;
      bad_r   <= 1'b0;
      start_r <= 1'b1;
    end else begin
      acc_r   <= acc_nxt;
      neg_r   <= neg_nxt;
      bad_r   <= bad_nxt;
      start_r <= start_nxt;
    end
  end

endmodule

// ===== hdl/radix_literal_parser_unit.sv =====
// Top level of the radix literal parser: input register, conversion, result register.
// A word-end beat waits in the input register for room, then loads the result register.
// Throughput: one character beat per cycle while word ends find room; a word-end beat
// after a word compiled as a full literal also waits while the second result is sent.
// The rate is set by the single multiply-accumulate of accumulator times base.
// Reset (rst_n low, synchronous) empties both registers, clears the word state
// and returns the configuration registers to base 10 and zero opcodes and span.
`include "radix_literal_parser_unit_defines.svh"

module radix_literal_parser_unit
  import rlp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [7:0]               in_tdata,   // [7:0] character
  input  logic                     in_tlast,   // word_end
  input  logic                     in_tuser,   // [0] compile_mode
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [VALUE_BITS-1:0]    out_tdata,  // [15:0] cell_value
  output logic                     out_tlast,  // final_result
  output logic [ACTION_BITS-1:0]   out_tuser,  // [1:0] action
  input  logic                     cfg_we,
  input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  cfg_t                   cfg_r;
  logic                   in_v_r;
  logic [CHAR_BITS-1:0]   in_char_r;
  logic                   in_end_r;
  logic                   in_comp_r;
  logic                   out_v_r;
  logic [VALUE_BITS-1:0]  out_value_r;
  logic [ACTION_BITS-1:0] out_action_r;
  logic                   out_last_r;
  logic                   hold_v_r;
  logic [VALUE_BITS-1:0]  hold_value_r;

  logic      out_free;
  logic      room;
  logic      fire;
  conv_res_t res;

  // The word-end beat needs a free result register and no pending second result.
  assign out_free  = !out_v_r || out_tready;
  assign room      = out_free && !hold_v_r;
  assign fire      = in_v_r && (!in_end_r || room);
  assign in_tready = !in_v_r || fire;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.number_base        <= BASE_RESET;
      cfg_r.literal_opcode     <= '0;
      cfg_r.first_short_opcode <= '0;
      cfg_r.short_literal_span <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_NUMBER_BASE: cfg_r.number_base        <= cfg_wdata[BASE_BITS-1:0];
        REG_LITERAL_OPC: cfg_r.literal_opcode     <= cfg_wdata[OPC_BITS-1:0];
        REG_FIRST_SHORT: cfg_r.first_short_opcode <= cfg_wdata[OPC_BITS-1:0];
        REG_SHORT_SPAN:  cfg_r.short_literal_span <= cfg_wdata[SPAN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_char_r <= in_tdata[CHAR_BITS-1:0];
      in_end_r  <= in_tlast;
      in_comp_r <= in_tuser;
    end
  end

  rlp_word_conv u_conv (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (fire),
    .character    (in_char_r),
    .word_end     (in_end_r),
    .compile_mode (in_comp_r),
    .cfg          (cfg_r),
    .res          (res)
  );

  // Result register; the second word of a full literal waits in the hold slot.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      hold_v_r <= 1'b0;
    end else if (out_free) begin
      if (hold_v_r) begin
        out_v_r  <= 1'b1;
        hold_v_r <= 1'b0;
      end else begin
        out_v_r  <= fire && res.has_res;
        hold_v_r <= fire && res.has_res && res.two_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (hold_v_r) begin
        out_value_r  <= hold_value_r;
        out_action_r <= ACT_APPEND;
        out_last_r   <= 1'b1;
      end else begin
        out_value_r  <= res.first_value;
        out_action_r <= res.action;
        out_last_r   <= !res.two_res;
        hold_value_r <= res.second_value;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_value_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_action_r;

  // A pending second word always sits behind a shown literal opcode.
  `RLP_ASSERT_IMPLY(a_hold_behind_opcode, hold_v_r,
    out_v_r && !out_last_r && (out_action_r == ACT_APPEND))
  // A non-final result always has its follower queued.
  `RLP_ASSERT_IMPLY(a_nonfinal_has_follower, out_v_r && !out_last_r, hold_v_r)
  // A full literal loads both the opcode and the pending value.
  `RLP_ASSERT_NEXT(a_full_literal_loads_pair, fire && res.has_res && res.two_res,
    out_v_r && hold_v_r)
  // A word end is never taken while a second word is pending.
  `RLP_ASSERT_IMPLY(a_no_end_over_hold, fire && in_end_r, !hold_v_r && out_free)

endmodule
